// File: rtl/rwt_pkg.sv
// Shared types and constants of the retransmit window tracker.
package rwt_pkg;

	localparam int WINDOW_SIZE_DEF = 16;
	localparam int RESULT_CAP = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

	localparam logic [2:0] OP_REGISTER = 3'd0;
	localparam logic [2:0] OP_RELEASE  = 3'd1;
	localparam logic [2:0] OP_TICK     = 3'd2;
	localparam logic [2:0] OP_CHECK    = 3'd3;
	localparam logic [2:0] OP_LIST     = 3'd4;

	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	typedef enum logic [2:0] {
		CMD_REGISTER,
		CMD_RELEASE,
		CMD_TICK,
		CMD_CHECK,
		CMD_LIST,
		CMD_NOP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [31:0] seq;
		logic [15:0] handle;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [4:0]  free_slots;
		logic        entry_present;
		logic [31:0] entry_seq;
		logic [15:0] entry_handle;
		logic [7:0]  entry_retries;
		logic        last;
	} res_t;

	typedef enum logic [2:0] {
		EX_IDLE,
		EX_SCAN,
		EX_READ,
		EX_EVAL,
		EX_FINISH
	} ex_state_t;

endpackage

// File: rtl/rwt_fifo.sv
// Small synchronous FIFO used for the command and result queues.
module rwt_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// File: rtl/rwt_front.sv
// Front end: takes input beats, decodes the operation and queues commands.
module rwt_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic [2:0]    operation,
	input  logic [31:0]   seq_number,
	input  logic [15:0]   packet_handle,
	output logic          cmd_valid,
	output rwt_pkg::cmd_t cmd,
	input  logic          cmd_pop
);
	import rwt_pkg::*;

	cmd_t dec;
	logic q_empty;
	logic [$bits(cmd_t)-1:0] q_rdata;

	always_comb begin
		dec.seq    = seq_number;
		dec.handle = packet_handle;
		unique case (operation)
			OP_REGISTER: dec.kind = CMD_REGISTER;
			OP_RELEASE:  dec.kind = CMD_RELEASE;
			OP_TICK:     dec.kind = CMD_TICK;
			OP_CHECK:    dec.kind = CMD_CHECK;
			OP_LIST:     dec.kind = CMD_LIST;
			default:     dec.kind = CMD_NOP;
		endcase
	end

	rwt_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (dec),
		.full  (full),
		.pop   (cmd_pop),
		.rdata (q_rdata),
		.empty (q_empty)
	);

	assign cmd_valid = !q_empty;
	assign cmd       = cmd_t'(q_rdata);

endmodule

// File: rtl/rwt_exec.sv
// Back end: slot table, key match, time counter and the ordered timeout/list walk.
module rwt_exec #(
	parameter int WINDOW_SIZE = rwt_pkg::WINDOW_SIZE_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [31:0]   timeout,
	input  logic          cmd_valid,
	input  rwt_pkg::cmd_t cmd,
	output logic          cmd_pop,
	input  logic          res_full,
	output logic          res_push,
	output rwt_pkg::res_t res
);
	import rwt_pkg::*;

	localparam int IW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
	localparam int FW = $clog2(WINDOW_SIZE + 1);
	localparam int CW = $clog2(RESULT_CAP + 1);

	typedef struct packed {
		logic [15:0] handle;
		logic [31:0] sent_time;
		logic [7:0]  retries;
	} slot_ent_t;

	ex_state_t state_q, state_d;

	logic [WINDOW_SIZE-1:0] valid_q;
	logic [31:0] seq_q [WINDOW_SIZE];
	slot_ent_t mem [WINDOW_SIZE];
	slot_ent_t rd_q;
	logic [FW-1:0] free_q;
	logic [31:0] time_q;

	logic check_q, found_q, have_prev_q, pend_valid_q;
	logic [IW-1:0] scan_idx_q, best_idx_q;
	logic [31:0] best_seq_q, prev_q;
	logic [CW-1:0] pick_cnt_q;
	logic [31:0] pend_seq_q;
	logic [15:0] pend_handle_q;
	logic [7:0] pend_retries_q;

	logic [WINDOW_SIZE-1:0] match_vec;
	logic match_any;
	logic [IW-1:0] match_idx, free_idx, reg_idx;
	logic reg_ok, walk_cmd;
	logic [31:0] scan_seq, elapsed;
	logic scan_last, cand, skip, eval_go, emit, cap_hit;
	logic [7:0] new_retries;
	logic mem_we;
	logic [IW-1:0] mem_waddr;
	slot_ent_t mem_wdata;

	// key match and lowest free slot; downward loop leaves the lowest index
	always_comb begin
		match_idx = '0;
		free_idx  = '0;
		for (int i = WINDOW_SIZE - 1; i >= 0; i--) begin
			match_vec[i] = valid_q[i] && (seq_q[i] == cmd.seq);
			if (match_vec[i]) begin
				match_idx = IW'(i);
			end
			if (!valid_q[i]) begin
				free_idx = IW'(i);
			end
		end
	end

	assign match_any = |match_vec;
	assign reg_idx   = match_any ? match_idx : free_idx;
	assign reg_ok    = (free_q != '0);
	assign walk_cmd  = (cmd.kind == CMD_CHECK) || (cmd.kind == CMD_LIST);

	// one slot per cycle: smallest key above the previous one
	assign scan_seq  = seq_q[scan_idx_q];
	assign scan_last = (scan_idx_q == IW'(WINDOW_SIZE - 1));
	assign cand      = valid_q[scan_idx_q]
		&& (!have_prev_q || (scan_seq > prev_q))
		&& (!found_q || (scan_seq < best_seq_q));

	assign elapsed     = time_q - rd_q.sent_time;
	assign skip        = check_q && !(elapsed > timeout);
	assign eval_go     = (state_q == EX_EVAL) && (skip || !pend_valid_q || !res_full);
	assign emit        = eval_go && !skip;
	assign cap_hit     = (pick_cnt_q == CW'(RESULT_CAP - 1));
	assign new_retries = !check_q ? rd_q.retries :
		(rd_q.retries == 8'hFF) ? 8'hFF : rd_q.retries + 8'd1;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			EX_IDLE: begin
				if (cmd_valid && walk_cmd) begin
					state_d = EX_SCAN;
				end
			end
			EX_SCAN: begin
				if (scan_last) begin
					state_d = (found_q || cand) ? EX_READ : EX_FINISH;
				end
			end
			EX_READ: state_d = EX_EVAL;
			EX_EVAL: begin
				if (eval_go) begin
					state_d = (emit && cap_hit) ? EX_FINISH : EX_SCAN;
				end
			end
			EX_FINISH: begin
				if (!res_full) begin
					state_d = EX_IDLE;
				end
			end
			default: state_d = EX_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop   = 1'b0;
		res_push  = 1'b0;
		res       = '0;
		res.status     = ST_DONE;
		res.free_slots = 5'(free_q);
		mem_we    = 1'b0;
		mem_waddr = best_idx_q;
		mem_wdata = '{handle: rd_q.handle, sent_time: time_q, retries: new_retries};
		unique case (state_q)
			EX_IDLE: begin
				if (cmd_valid) begin
					if (walk_cmd) begin
						cmd_pop = 1'b1;
					end else if (!res_full) begin
						cmd_pop  = 1'b1;
						res_push = 1'b1;
						res.last = 1'b1;
						unique case (cmd.kind)
							CMD_REGISTER: begin
								if (!reg_ok) begin
									res.status = ST_FULL;
								end else begin
									mem_we    = 1'b1;
									mem_waddr = reg_idx;
									mem_wdata = '{handle: cmd.handle, sent_time: time_q,
										retries: 8'd0};
									res.free_slots = 5'(free_q - FW'(!match_any));
								end
							end
							CMD_RELEASE: begin
								if (match_any) begin
									res.free_slots = 5'(free_q + FW'(1));
								end else begin
									res.status = ST_NOT_FOUND;
								end
							end
							default: ;
						endcase
					end
				end
			end
			EX_EVAL: begin
				// the held entry goes out once a later one proves it is not last
				if (emit && pend_valid_q) begin
					res_push          = 1'b1;
					res.entry_present = 1'b1;
					res.entry_seq     = pend_seq_q;
					res.entry_handle  = pend_handle_q;
					res.entry_retries = pend_retries_q;
				end
				if (emit && check_q) begin
					mem_we = 1'b1;
				end
			end
			EX_FINISH: begin
				if (!res_full) begin
					res_push = 1'b1;
					res.last = 1'b1;
					if (pend_valid_q) begin
						res.entry_present = 1'b1;
						res.entry_seq     = pend_seq_q;
						res.entry_handle  = pend_handle_q;
						res.entry_retries = pend_retries_q;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= EX_IDLE;
			valid_q      <= '0;
			free_q       <= FW'(WINDOW_SIZE);
			time_q       <= '0;
			check_q      <= 1'b0;
			found_q      <= 1'b0;
			have_prev_q  <= 1'b0;
			pend_valid_q <= 1'b0;
			scan_idx_q   <= '0;
			pick_cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if ((state_q == EX_IDLE) && cmd_pop) begin
				case (cmd.kind) inside
					CMD_REGISTER: begin
						if (reg_ok) begin
							valid_q[reg_idx] <= 1'b1;
							if (!match_any) begin
								free_q <= free_q - FW'(1);
							end
						end
					end
					CMD_RELEASE: begin
						if (match_any) begin
							valid_q[match_idx] <= 1'b0;
							free_q <= free_q + FW'(1);
						end
					end
					CMD_TICK: time_q <= time_q + 32'd1;
					CMD_CHECK, CMD_LIST: begin
						check_q      <= (cmd.kind == CMD_CHECK);
						scan_idx_q   <= '0;
						found_q      <= 1'b0;
						have_prev_q  <= 1'b0;
						pick_cnt_q   <= '0;
						pend_valid_q <= 1'b0;
					end
					default: ;
				endcase
			end
			if (state_q == EX_SCAN) begin
				if (cand) begin
					found_q <= 1'b1;
				end
				scan_idx_q <= scan_last ? '0 : scan_idx_q + IW'(1);
			end
			if (eval_go) begin
				have_prev_q <= 1'b1;
				found_q     <= 1'b0;
				if (emit) begin
					pend_valid_q <= 1'b1;
					pick_cnt_q   <= pick_cnt_q + CW'(1);
				end
			end
			if ((state_q == EX_FINISH) && !res_full) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == EX_IDLE) && cmd_pop && (cmd.kind == CMD_REGISTER) && reg_ok) begin
			seq_q[reg_idx] <= cmd.seq;
		end
		if ((state_q == EX_SCAN) && cand) begin
			best_idx_q <= scan_idx_q;
			best_seq_q <= scan_seq;
		end
		if (eval_go) begin
			prev_q <= best_seq_q;
		end
		if (emit) begin
			pend_seq_q     <= best_seq_q;
			pend_handle_q  <= rd_q.handle;
			pend_retries_q <= new_retries;
		end
	end

	// slot payload memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[best_idx_q];
	end

endmodule

// File: rtl/retransmit_window_tracker.sv
// Retransmit window tracker: sender-side table of unacknowledged packets keyed by sequence
// number. Commands enter through a two-entry queue and results leave through another, so
// either side may stall. Register, release, tick and unknown codes are done straight from
// the idle state in the back end, each giving one result. Check and list walk the table
// in ascending key order: each step scans all WINDOW_SIZE slots one per cycle to find the
// next key, then reads that slot's payload memory and evaluates it; the slot scan sets
// the cost of a walk, which ends early once the cap is reached. A check reports and
// restamps each entry whose elapsed ticks exceed timeout, at most 16 per command.
// The timeout register may be written only while no command is in flight.
module retransmit_window_tracker #(
	parameter int WINDOW_SIZE = rwt_pkg::WINDOW_SIZE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  operation,
	input  logic [31:0] seq_number,
	input  logic [15:0] packet_handle,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  status,
	output logic [4:0]  free_slots,
	output logic        entry_present,
	output logic [31:0] entry_seq,
	output logic [15:0] entry_handle,
	output logic [7:0]  entry_retries,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);
	import rwt_pkg::*;

	logic [31:0] timeout_q;
	logic cmd_valid, cmd_pop, res_full, res_push;
	cmd_t cmd;
	res_t res_in, res_out;
	logic [$bits(res_t)-1:0] res_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			timeout_q <= cfg_data;
		end
	end

	rwt_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.operation    (operation),
		.seq_number   (seq_number),
		.packet_handle(packet_handle),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop)
	);

	rwt_exec #(
		.WINDOW_SIZE(WINDOW_SIZE)
	) u_exec (
		.clk      (clk),
		.arst_n   (arst_n),
		.timeout  (timeout_q),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res_in)
	);

	rwt_fifo #(
		.WIDTH($bits(res_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_in),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_rdata),
		.empty (empty)
	);

	assign res_out       = res_t'(res_rdata);
	assign status        = res_out.status;
	assign free_slots    = res_out.free_slots;
	assign entry_present = res_out.entry_present;
	assign entry_seq     = res_out.entry_seq;
	assign entry_handle  = res_out.entry_handle;
	assign entry_retries = res_out.entry_retries;
	assign last          = res_out.last;

endmodule

// File: rtl/rwt_checker.sv
// Port-level assertions for the retransmit window tracker, bound to the top level.
module rwt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [1:0]  status,
	input logic [4:0]  free_slots,
	input logic        entry_present,
	input logic [31:0] entry_seq,
	input logic        last
);
	import rwt_pkg::*;

	// a result without an entry always closes its command
	a_bare_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !entry_present |-> last)
		else $error("result without entry not marked last");

	// listed or timed-out entries never carry an error status
	a_entry_done: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && entry_present |-> status == ST_DONE)
		else $error("entry beat with error status");

	// a refused register means every slot is taken
	a_full_no_free: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && status == ST_FULL |-> free_slots == 5'd0)
		else $error("window-full status with free slots");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(entry_seq) && $stable(last))
		else $error("waiting result beat changed");

endmodule

bind retransmit_window_tracker rwt_checker u_rwt_checker (.*);

// File: verif/retransmit_window_tracker_test.sv
// Self-checking testbench for the retransmit window tracker: directed table, random traffic.
module retransmit_window_tracker_test;
	import rwt_pkg::*;

	localparam int WIN = WINDOW_SIZE_DEF;
	localparam int STALL_LIMIT = 5000;
	localparam int END_PAUSE = 2 * (WIN + 2) + 8;
	localparam int REPORT_MAX = 10;
	localparam int HOLD_CYCLES = 400;
	localparam logic [2:0] OP_BAD_FIRST = 3'd5;
	localparam logic [2:0] OP_BAD_LAST = 3'd7;

	typedef struct packed {
		bit          is_cfg;
		logic [2:0]  op;
		logic [31:0] seq;
		logic [15:0] hnd;
		bit          typed;
		logic [1:0]  st;
		logic [4:0]  fs;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [2:0]  operation = '0;
	logic [31:0] seq_number = '0;
	logic [15:0] packet_handle = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [1:0]  status;
	logic [4:0]  free_slots;
	logic        entry_present;
	logic [31:0] entry_seq;
	logic [15:0] entry_handle;
	logic [7:0]  entry_retries;
	logic        last;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = '0;

	// predictor state
	bit          tbl_valid [WIN];
	logic [31:0] tbl_seq [WIN];
	logic [15:0] tbl_handle [WIN];
	logic [31:0] tbl_stamp [WIN];
	logic [7:0]  tbl_retries [WIN];
	logic [31:0] tick_now = '0;
	logic [31:0] timeout_cfg = TIMEOUT_RESET;

	res_t expected_reports [$];
	int   mismatch_count = 0;
	int   results_seen = 0;
	int   idle_cycles = 0;
	int   burst_left = 0;
	int   rx_cycle = 0;
	int   hold_left = 0;
	bit   hold_done = 1'b0;

	stim_row_t directed_rows [24] = '{
		'{1'b0, OP_LIST,      32'h0,         16'h0,    1'b1, ST_DONE,      5'd16},
		'{1'b0, OP_CHECK,     32'h0,         16'h0,    1'b1, ST_DONE,      5'd16},
		'{1'b0, OP_RELEASE,   32'hFFFF_FFFF, 16'h0,    1'b1, ST_NOT_FOUND, 5'd16},
		'{1'b0, OP_REGISTER,  32'h0,         16'h0,    1'b1, ST_DONE,      5'd15},
		'{1'b0, OP_REGISTER,  32'hFFFF_FFFF, 16'hFFFF, 1'b1, ST_DONE,      5'd14},
		'{1'b0, OP_REGISTER,  32'h0,         16'h1234, 1'b1, ST_DONE,      5'd14},
		'{1'b0, OP_BAD_FIRST, 32'h5A5A_A5A5, 16'hA5A5, 1'b1, ST_DONE,      5'd14},
		'{1'b0, OP_BAD_LAST,  32'hFFFF_FFFF, 16'hFFFF, 1'b1, ST_DONE,      5'd14},
		'{1'b0, OP_LIST,      32'h0,         16'h0,    1'b0, ST_DONE,      5'd0},
		'{1'b1, OP_TICK,      32'h1,         16'h0,    1'b0, ST_DONE,      5'd0},
		'{1'b0, OP_TICK,      32'h0,         16'h0,    1'b1, ST_DONE,      5'd14},
		'{1'b0, OP_CHECK,     32'h0,         16'h0,    1'b0, ST_DONE,      5'd0},
		'{1'b0, OP_TICK,      32'h0,         16'h0,    1'b1, ST_DONE,      5'd14},
		'{1'b0, OP_CHECK,     32'h0,         16'h0,    1'b0, ST_DONE,      5'd0},
		'{1'b0, OP_RELEASE,   32'h0,         16'h0,    1'b1, ST_DONE,      5'd15},
		'{1'b0, OP_RELEASE,   32'h0,         16'h0,    1'b1, ST_NOT_FOUND, 5'd15},
		'{1'b0, OP_REGISTER,  32'h8000_0000, 16'h8000, 1'b1, ST_DONE,      5'd14},
		'{1'b0, OP_TICK,      32'h0,         16'h0,    1'b1, ST_DONE,      5'd14},
		'{1'b0, OP_TICK,      32'h0,         16'h0,    1'b1, ST_DONE,      5'd14},
		'{1'b0, OP_CHECK,     32'h0,         16'h0,    1'b0, ST_DONE,      5'd0},
		'{1'b1, OP_TICK,      32'hFFFF_FFFF, 16'h0,    1'b0, ST_DONE,      5'd0},
		'{1'b0, OP_TICK,      32'h0,         16'h0,    1'b1, ST_DONE,      5'd14},
		'{1'b0, OP_CHECK,     32'h0,         16'h0,    1'b0, ST_DONE,      5'd0},
		'{1'b0, OP_LIST,      32'h0,         16'h0,    1'b0, ST_DONE,      5'd0}
	};

	retransmit_window_tracker uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.operation(operation),
		.seq_number(seq_number),
		.packet_handle(packet_handle),
		.empty(empty),
		.pop(pop),
		.status(status),
		.free_slots(free_slots),
		.entry_present(entry_present),
		.entry_seq(entry_seq),
		.entry_handle(entry_handle),
		.entry_retries(entry_retries),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int find_slot(logic [31:0] key);
		for (int i = 0; i < WIN; i++)
			if (tbl_valid[i] && tbl_seq[i] == key)
				return i;
		return -1;
	endfunction

	function automatic int used_slots();
		int n;
		n = 0;
		for (int i = 0; i < WIN; i++)
			if (tbl_valid[i])
				n++;
		return n;
	endfunction

	// Updates the window table for one command and queues the result beats it causes.
	function automatic void window_predict(logic [2:0] op, logic [31:0] key, logic [15:0] hnd);
		int slot;
		int best;
		int picks [$];
		bit have_prev;
		logic [31:0] prev;
		logic [31:0] elapsed;
		logic [1:0] st;
		res_t r;
		st = ST_DONE;
		have_prev = 1'b0;
		prev = '0;
		case (op) inside
			OP_REGISTER: begin
				if (used_slots() >= WIN) begin
					st = ST_FULL;
				end else begin
					slot = find_slot(key);
					if (slot < 0)
						for (int i = WIN - 1; i >= 0; i--)
							if (!tbl_valid[i])
								slot = i;
					tbl_valid[slot] = 1'b1;
					tbl_seq[slot] = key;
					tbl_handle[slot] = hnd;
					tbl_stamp[slot] = tick_now;
					tbl_retries[slot] = '0;
				end
			end
			OP_RELEASE: begin
				slot = find_slot(key);
				if (slot < 0)
					st = ST_NOT_FOUND;
				else
					tbl_valid[slot] = 1'b0;
			end
			OP_TICK: tick_now = tick_now + 32'd1;
			OP_CHECK, OP_LIST: begin
				// ascending key walk; a check skips entries still inside the timeout
				while (1) begin
					best = -1;
					for (int i = 0; i < WIN; i++)
						if (tbl_valid[i] && !(have_prev && tbl_seq[i] <= prev)
								&& (best < 0 || tbl_seq[i] < tbl_seq[best]))
							best = i;
					if (best < 0)
						break;
					have_prev = 1'b1;
					prev = tbl_seq[best];
					elapsed = tick_now - tbl_stamp[best];
					if (op == OP_CHECK && elapsed <= timeout_cfg)
						continue;
					if (picks.size() >= RESULT_CAP)
						break;
					if (op == OP_CHECK) begin
						if (tbl_retries[best] != 8'hFF)
							tbl_retries[best] = tbl_retries[best] + 8'd1;
						tbl_stamp[best] = tick_now;
					end
					picks = {picks, best};
				end
			end
			default: ;
		endcase
		r = '0;
		r.status = st;
		r.free_slots = 5'(WIN - used_slots());
		r.last = 1'b1;
		if (picks.size() == 0) begin
			expected_reports = {expected_reports, r};
		end else begin
			foreach (picks[k]) begin
				r.entry_present = 1'b1;
				r.entry_seq = tbl_seq[picks[k]];
				r.entry_handle = tbl_handle[picks[k]];
				r.entry_retries = tbl_retries[picks[k]];
				r.last = (k == picks.size() - 1);
				expected_reports = {expected_reports, r};
			end
		end
	endfunction

	// Offers one command in the current burst; a typed row overrides the predicted beat.
	task automatic put_cmd(logic [2:0] op, logic [31:0] key, logic [15:0] hnd,
			bit typed, logic [1:0] st, logic [4:0] fs);
		int gap;
		res_t r;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				push <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		push <= 1'b1;
		operation <= op;
		seq_number <= key;
		packet_handle <= hnd;
		do @(posedge clk); while (full);
		window_predict(op, key, hnd);
		if (typed) begin
			r = '0;
			r.status = st;
			r.free_slots = fs;
			r.last = 1'b1;
			expected_reports[expected_reports.size() - 1] = r;
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		push <= 1'b0;
		burst_left = 0;
		while (expected_reports.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_timeout(logic [31:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		timeout_cfg = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Keys come from a small pool so that releases and overwrites hit often.
	task automatic random_phase(int count);
		logic [31:0] keys [24];
		logic [31:0] k;
		logic [2:0] op;
		int pick;
		foreach (keys[i])
			keys[i] = $urandom;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			k = keys[$urandom_range(0, 23)];
			if (pick < 30) begin
				op = OP_REGISTER;
			end else if (pick < 55) begin
				op = OP_RELEASE;
				if ($urandom_range(0, 4) == 0)
					k = $urandom;
			end else if (pick < 78) begin
				op = OP_TICK;
			end else if (pick < 90) begin
				op = OP_CHECK;
			end else if (pick < 97) begin
				op = OP_LIST;
			end else begin
				op = 3'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST));
			end
			put_cmd(op, k, 16'($urandom_range(0, 16'hFFFF)), 1'b0, ST_DONE, '0);
		end
	endtask

	initial begin
		foreach (tbl_valid[i]) begin
			tbl_valid[i] = 1'b0;
			tbl_seq[i] = '0;
			tbl_handle[i] = '0;
			tbl_stamp[i] = '0;
			tbl_retries[i] = '0;
		end
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg)
				write_timeout(directed_rows[i].seq);
			else
				put_cmd(directed_rows[i].op, directed_rows[i].seq, directed_rows[i].hnd,
					directed_rows[i].typed, directed_rows[i].st, directed_rows[i].fs);
		end
		write_timeout(32'd3);
		random_phase(80);
		write_timeout(32'd1);
		random_phase(80);
		write_timeout(32'd12);
		random_phase(80);
		write_timeout(32'($urandom_range(2, 40)));
		random_phase(80);
		// fill the window, knock on it once more, then time every entry out
		write_timeout(32'd1);
		repeat (WIN)
			put_cmd(OP_REGISTER, $urandom, 16'($urandom_range(0, 16'hFFFF)), 1'b0, ST_DONE, '0);
		put_cmd(OP_REGISTER, tbl_seq[0], 16'hBEEF, 1'b1, ST_FULL, 5'd0);
		for (int rnd = 0; rnd < 3; rnd++) begin
			put_cmd(OP_TICK, $urandom, '0, 1'b0, ST_DONE, '0);
			put_cmd(OP_TICK, $urandom, '0, 1'b0, ST_DONE, '0);
			put_cmd(OP_CHECK, $urandom, '0, 1'b0, ST_DONE, '0);
		end
		put_cmd(OP_LIST, '0, '0, 1'b0, ST_DONE, '0);
		write_timeout(TIMEOUT_RESET);
		put_cmd(OP_CHECK, '0, '0, 1'b0, ST_DONE, '0);
		wait_drained();
		repeat (END_PAUSE) @(negedge clk);
		if (mismatch_count == 0 && expected_reports.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Receiver: rotating stall pattern, plus one long hold so the block backs up.
	initial begin
		forever begin
			@(negedge clk);
			rx_cycle++;
			if (!hold_done && results_seen >= 60) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				case ((rx_cycle / 150) % 4)
					0: pop <= 1'b1;
					1: pop <= 1'($urandom_range(0, 1));
					2: pop <= (rx_cycle % 5 == 0);
					default: pop <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin : result_check
		res_t got;
		res_t want;
		if (arst_n && pop && !empty) begin
			results_seen++;
			got.status = status;
			got.free_slots = free_slots;
			got.entry_present = entry_present;
			got.entry_seq = entry_seq;
			got.entry_handle = entry_handle;
			got.entry_retries = entry_retries;
			got.last = last;
			if (expected_reports.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_MAX)
					$display("%0t: result beat with nothing expected: %p", $time, got);
			end else begin
				want = expected_reports.pop_front();
				if (got.status !== want.status || got.free_slots !== want.free_slots
						|| got.entry_present !== want.entry_present
						|| got.entry_seq !== want.entry_seq
						|| got.entry_handle !== want.entry_handle
						|| got.entry_retries !== want.entry_retries
						|| got.last !== want.last) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX)
						$display("%0t: result mismatch\n  expected %p\n  actual   %p",
							$time, want, got);
				end
			end
		end
	end

	// Watchdog: any accepted beat on any channel counts as progress.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

endmodule
